// ----- hw/rtl/bpk_pkg.sv -----
// bpk_pkg: shared types and constants of the bitmap row bit packer
// no dependencies
`default_nettype none

package bpk_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned CountW  = 3;
  localparam int unsigned PosW    = 13;
  localparam int unsigned RowW    = 16;

  typedef struct packed {
    logic [ByteW-1:0] packed_byte;
    logic             last;
  } result_t;

  typedef struct packed {
    logic [ByteW-1:0]  carry_byte;
    logic [CountW-1:0] carry_count;
    logic [PosW-1:0]   row_pos;
  } pack_state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/bpk_pack_core.sv -----
// bpk_pack_core: one-word merge of a row byte into the carry, giving up to two results
// depends on bpk_pkg
`default_nettype none

module bpk_pack_core (
  input  bpk_pkg::pack_state_t          st_i,
  input  logic [bpk_pkg::RowW-1:0]      row_width_bits_i,
  input  logic [bpk_pkg::ByteW-1:0]     data_byte_i,
  input  logic                          last_of_image_i,
  output bpk_pkg::pack_state_t          st_o,
  output logic [1:0]                    res_n_o,
  output bpk_pkg::result_t              res0_o,
  output bpk_pkg::result_t              res1_o
);
  import bpk_pkg::*;

  logic [PosW-1:0]     full;
  logic [2:0]          extra;
  logic [2*ByteW-1:0]  sh_b;
  logic [ByteW-1:0]    masked;
  logic [2*ByteW-1:0]  sh_m;
  logic [3:0]          sum;
  logic [PosW-1:0]     pos_inc;
  logic                emitted;
  logic [ByteW-1:0]    emit_val;
  logic                row_end;
  pack_state_t         nxt;

  always_comb begin
    full     = row_width_bits_i[RowW-1:3];
    extra    = row_width_bits_i[2:0];
    sh_b     = {data_byte_i, 8'h00} >> st_i.carry_count;
    masked   = data_byte_i & ~(8'hFF >> extra);
    sh_m     = {masked, 8'h00} >> st_i.carry_count;
    sum      = {1'b0, extra} + {1'b0, st_i.carry_count};
    pos_inc  = st_i.row_pos + {{(PosW-1){1'b0}}, 1'b1};
    emitted  = 1'b0;
    emit_val = '0;
    row_end  = 1'b0;
    nxt      = st_i;

    if (st_i.row_pos < full) begin
      emit_val       = st_i.carry_byte | sh_b[2*ByteW-1:ByteW];
      emitted        = 1'b1;
      nxt.carry_byte = sh_b[ByteW-1:0];
      row_end        = (pos_inc == full) && (extra == 3'd0);
    end else begin
      if (extra != 3'd0) begin
        if (sum[3]) begin
          emit_val       = st_i.carry_byte | sh_m[2*ByteW-1:ByteW];
          emitted        = 1'b1;
          nxt.carry_byte = sh_m[ByteW-1:0];
        end else begin
          nxt.carry_byte = st_i.carry_byte | sh_m[2*ByteW-1:ByteW];
        end
        nxt.carry_count = sum[2:0];
      end
      row_end = 1'b1;
    end

    nxt.row_pos = row_end ? '0 : pos_inc;

    res0_o  = '0;
    res1_o  = '0;
    res_n_o = 2'd0;
    if (emitted) begin
      res0_o.packed_byte = emit_val;
      res0_o.last        = last_of_image_i && (nxt.carry_count == 3'd0);
      res_n_o            = 2'd1;
      if (last_of_image_i && (nxt.carry_count != 3'd0)) begin
        res1_o.packed_byte = nxt.carry_byte;
        res1_o.last        = 1'b1;
        res_n_o            = 2'd2;
      end
    end else if (last_of_image_i && (nxt.carry_count != 3'd0)) begin
      res0_o.packed_byte = nxt.carry_byte;
      res0_o.last        = 1'b1;
      res_n_o            = 2'd1;
    end

    st_o = last_of_image_i ? '0 : nxt;
  end

endmodule

`default_nettype wire

// ----- hw/rtl/bpk_result_fifo.sv -----
// bpk_result_fifo: three-entry result queue, up to two writes and one read per cycle
// depends on bpk_pkg
`default_nettype none

module bpk_result_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [1:0]       push_n_i,
  input  bpk_pkg::result_t push0_i,
  input  bpk_pkg::result_t push1_i,
  output logic             room_o,
  output logic             out_valid_o,
  output bpk_pkg::result_t out_res_o,
  input  logic             out_stall_i
);
  import bpk_pkg::*;

  localparam int unsigned Depth = 3;

  result_t    ent_q [Depth];
  result_t    ent_d [Depth];
  logic [1:0] count_q, count_d;
  logic [1:0] base;
  logic       pop;

  always_comb begin
    pop  = (count_q != 2'd0) && !out_stall_i;
    base = count_q - {1'b0, pop};
    for (int i = 0; i < Depth; i++) begin
      ent_d[i] = ent_q[i];
    end
    if (pop) begin
      for (int i = 0; i < Depth - 1; i++) begin
        ent_d[i] = ent_q[i+1];
      end
    end
    for (int i = 0; i < Depth; i++) begin
      if ((push_n_i != 2'd0) && (2'(i) == base)) begin
        ent_d[i] = push0_i;
      end
      if ((push_n_i == 2'd2) && (2'(i) == base + 2'd1)) begin
        ent_d[i] = push1_i;
      end
    end
    count_d = base + push_n_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < Depth; i++) begin
      ent_q[i] <= ent_d[i];
    end
  end

  assign room_o      = (count_q <= 2'd1);
  assign out_valid_o = (count_q != 2'd0);
  assign out_res_o   = ent_q[0];

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_n_i != 2'd0) |-> (count_q <= 2'd1))
    else $error("result queue written without room");

endmodule

`default_nettype wire

// ----- hw/rtl/bitmap_row_bit_packer.sv -----
// bitmap_row_bit_packer: strips row padding from a 1-bit-per-pixel byte stream
// depends on bpk_pkg, bpk_pack_core, bpk_result_fifo
//
// Input channel (in_valid_i / in_stall_o) carries one padded row byte per word,
// MSB first, with last_of_image_i on the final byte of the image. Output channel
// (out_valid_o / out_stall_i) carries the packed stream, last_o on its final word.
// A word moves when valid is high and stall is low.
// The configuration channel (cfg_valid_i / cfg_ready_o) writes row_width_bits;
// it is always ready. It must be written only while the block is idle; the block
// itself does not enforce this. One input word is taken per cycle while the queue
// has room. Each word yields zero, one or two results, which enter a three-entry
// result queue and are registered there before they are offered. Input is stalled
// while the queue holds two or more results, so with single results and no output
// stall the rate is one word per cycle; a word giving two results holds input
// stalled while the extra result is read. When the receiver stalls, results wait
// in the queue and input keeps being taken until it holds two entries.
// Reset clears carry, count, row position and the queue, and sets the row width to 8.
`default_nettype none

module bitmap_row_bit_packer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_row_width_bits_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_of_image_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  packed_byte_o,
  output logic        last_o
);
  import bpk_pkg::*;

  pack_state_t     st_q, st_d;
  logic [RowW-1:0] row_width_q;
  logic [1:0]      res_n;
  result_t         res0, res1, out_res;
  logic            room;
  logic            in_acc;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = !room;
  assign in_acc      = in_valid_i && room;

  bpk_pack_core u_core (
    .st_i             (st_q),
    .row_width_bits_i (row_width_q),
    .data_byte_i      (data_byte_i),
    .last_of_image_i  (last_of_image_i),
    .st_o             (st_d),
    .res_n_o          (res_n),
    .res0_o           (res0),
    .res1_o           (res1)
  );

  bpk_result_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_n_i    (in_acc ? res_n : 2'd0),
    .push0_i     (res0),
    .push1_i     (res1),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_res_o   (out_res),
    .out_stall_i (out_stall_i)
  );

  assign packed_byte_o = out_res.packed_byte;
  assign last_o        = out_res.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= '0;
      row_width_q <= 16'd8;
    end else begin
      if (in_acc) begin
        st_q <= st_d;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        row_width_q <= cfg_row_width_bits_i;
      end
    end
  end

  // carry is left aligned: bits below the pending ones are clear
  a_carry_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q.carry_byte & (8'hFF >> st_q.carry_count)) == 8'h00)
    else $error("carry holds bits below its count");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && last_of_image_i) |=> (st_q == '0))
    else $error("state not cleared after end of image");

  a_state_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_acc |=> $stable(st_q))
    else $error("state changed without an input word");

endmodule

`default_nettype wire

// ----- verif/bpk_stream_checker.sv -----
`timescale 1ns / 100ps
// bpk_stream_checker: predicts the packed stream of bitmap_row_bit_packer from the
// words accepted on its input and checks every result word; depends on bpk_pkg
module bpk_stream_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [15:0] cfg_row_width_bits_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  data_byte_i,
  input  logic        last_of_image_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [7:0]  packed_byte_i,
  input  logic        last_i,
  output int          mismatch_count_o,
  output int          pending_count_o
);
  import bpk_pkg::*;

  localparam logic [RowW-1:0] ResetWidth = 16'd8;
  localparam int MaxReports = 10;

  logic [RowW-1:0]   row_width_q;
  logic [ByteW-1:0]  carry_q;
  logic [CountW-1:0] count_q;
  logic [PosW-1:0]   pos_q;
  result_t           packed_q[$];
  int                mismatches;

  function automatic void pack_row_byte(input logic [ByteW-1:0] b, input logic fin);
    int unsigned full;
    int unsigned extra;
    int unsigned pos;
    int unsigned cnt;
    int unsigned m;
    int unsigned merged;
    logic        emitted;
    logic        row_end;
    result_t     word;
    full    = 32'(row_width_q) >> 3;
    extra   = 32'(row_width_q) & 7;
    pos     = 32'(pos_q);
    cnt     = 32'(count_q);
    emitted = 1'b0;
    row_end = 1'b0;
    word    = '0;
    if (pos < full) begin
      word.packed_byte = ByteW'(32'(carry_q) | (32'(b) >> cnt));
      emitted          = 1'b1;
      carry_q          = ByteW'(32'(b) << (8 - cnt));
      row_end          = (pos + 1 == full) && (extra == 0);
    end else begin
      // partial byte of the row, or a row with no used bits
      if (extra != 0) begin
        m      = 32'(b) & ((32'hFF << (8 - extra)) & 32'hFF);
        merged = (32'(carry_q) | (m >> cnt)) & 32'hFF;
        if (extra + cnt >= 8) begin
          word.packed_byte = ByteW'(merged);
          emitted          = 1'b1;
          carry_q          = ByteW'(m << (8 - cnt));
          cnt              = extra + cnt - 8;
        end else begin
          carry_q = ByteW'(merged);
          cnt     = cnt + extra;
        end
      end
      row_end = 1'b1;
    end
    count_q = CountW'(cnt);
    pos_q   = row_end ? '0 : PosW'(pos + 1);
    if (emitted) begin
      word.last = fin && (cnt == 0);
      packed_q  = {packed_q, word};
    end
    if (fin) begin
      if (cnt != 0) begin
        word.packed_byte = carry_q;
        word.last        = 1'b1;
        packed_q         = {packed_q, word};
      end
      carry_q = '0;
      count_q = '0;
      pos_q   = '0;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      row_width_q = ResetWidth;
      carry_q     = '0;
      count_q     = '0;
      pos_q       = '0;
      packed_q.delete();
      mismatches  = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (packed_q.size() == 0) begin
          if (mismatches < MaxReports) begin
            $display("unexpected word: packed_byte %02h last %0b", packed_byte_i, last_i);
          end
          mismatches++;
        end else begin
          want = packed_q.pop_front();
          if (packed_byte_i !== want.packed_byte || last_i !== want.last) begin
            if (mismatches < MaxReports) begin
              $display("mismatch: packed_byte %02h last %0b, expected %02h last %0b",
                       packed_byte_i, last_i, want.packed_byte, want.last);
            end
            mismatches++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        row_width_q = cfg_row_width_bits_i;
      end
      if (in_valid_i && !in_stall_i) begin
        pack_row_byte(data_byte_i, last_of_image_i);
      end
    end
    mismatch_count_o <= mismatches;
    pending_count_o  <= packed_q.size();
  end

endmodule

// ----- verif/bitmap_row_bit_packer_test.sv -----
`timescale 1ns / 100ps
// bitmap_row_bit_packer_test: drives padded row bytes and row widths into the packer
// with random gaps and stalls; depends on bitmap_row_bit_packer and bpk_stream_checker
module bitmap_row_bit_packer_test;

  localparam int unsigned ResetCycles   = 6;
  localparam int unsigned SettleCycles  = 8;
  localparam int unsigned ItemGoal      = 1350;
  localparam int unsigned MaxImageWords = 300;
  localparam int unsigned HoldLen       = 200;
  localparam int unsigned HoldPhase     = 2;
  localparam int unsigned PausePhase    = 3;
  localparam longint     TimeoutNs     = 64'd10_000_000;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [15:0] cfg_row_width_bits_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  data_byte_i;
  logic        last_of_image_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [7:0]  packed_byte_o;
  logic        last_o;

  int          mismatch_count;
  int          pending_count;
  int unsigned words_sent = 0;
  bit          calm = 1'b0;
  bit          hold_req = 1'b0;
  logic [15:0] corner_widths [$] = '{16'd1, 16'd7, 16'd8, 16'd9, 16'd15, 16'd16, 16'd17,
                                      16'd0, 16'hFFFF, 16'hFFF8, 16'hFFFE};

  bitmap_row_bit_packer dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_valid_i          (cfg_valid_i),
    .cfg_ready_o          (cfg_ready_o),
    .cfg_row_width_bits_i (cfg_row_width_bits_i),
    .in_valid_i           (in_valid_i),
    .in_stall_o           (in_stall_o),
    .data_byte_i          (data_byte_i),
    .last_of_image_i      (last_of_image_i),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .packed_byte_o        (packed_byte_o),
    .last_o               (last_o)
  );

  bpk_stream_checker pack_check (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_valid_i          (cfg_valid_i),
    .cfg_ready_i          (cfg_ready_o),
    .cfg_row_width_bits_i (cfg_row_width_bits_i),
    .in_valid_i           (in_valid_i),
    .in_stall_i           (in_stall_o),
    .data_byte_i          (data_byte_i),
    .last_of_image_i      (last_of_image_i),
    .out_valid_i          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .packed_byte_i        (packed_byte_o),
    .last_i               (last_o),
    .mismatch_count_o     (mismatch_count),
    .pending_count_o      (pending_count)
  );

  always #6 clk_i = ~clk_i;

  function automatic int unsigned idle_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic fin);
    int unsigned gap;
    gap = (calm || $urandom_range(0, 3) != 0) ? 0 : idle_len();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    data_byte_i     <= b;
    last_of_image_i <= fin;
    do @(posedge clk_i); while (in_stall_o);
    words_sent++;
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_count != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_width(input logic [15:0] w);
    wait_idle();
    cfg_valid_i          <= 1'b1;
    cfg_row_width_bits_i <= w;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_image(input logic [15:0] w);
    int unsigned row_bytes;
    int unsigned total;
    bit          broken;
    row_bytes = (w == 0) ? 1 : (32'(w) + 7) / 8;
    total     = row_bytes * $urandom_range(1, 4);
    broken    = ($urandom_range(0, 7) == 0);
    if (broken) begin
      total = $urandom_range(1, 24);
    end else if (total > MaxImageWords) begin
      total = $urandom_range(1, MaxImageWords);
    end
    for (int unsigned i = 0; i < total; i++) begin
      send_byte(8'($urandom_range(0, 255)),
                broken ? ($urandom_range(0, 5) == 0) : (i == total - 1));
    end
  endtask

  // receiver side: alternating free and stalled runs, plus one long hold on request
  initial begin
    int unsigned run_len;
    bit          stalling;
    run_len     = 0;
    stalling    = 1'b0;
    out_stall_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HoldLen - 1) @(posedge clk_i);
        hold_req = 1'b0;
        run_len  = 0;
      end else begin
        if (run_len == 0) begin
          stalling = !stalling;
          run_len  = stalling ? idle_len() : $urandom_range(1, 24);
        end
        run_len--;
        out_stall_i <= stalling && !calm;
      end
    end
  end

  initial begin
    int unsigned phase;
    int unsigned phase_start;
    int unsigned phase_goal;
    logic [15:0] w;
    rst_ni               = 1'b0;
    cfg_valid_i          = 1'b0;
    cfg_row_width_bits_i = '0;
    in_valid_i           = 1'b0;
    data_byte_i          = '0;
    last_of_image_i      = 1'b0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset width: whole bytes only
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b1);
    // short rows, pad bits set, flush of pending bits
    write_width(16'd3);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hE0, 1'b0);
    send_byte(8'h1F, 1'b0);
    send_byte(8'hFF, 1'b1);
    // image ends inside a row
    write_width(16'd20);
    send_byte(8'hAB, 1'b0);
    send_byte(8'hCD, 1'b1);
    // no used bits, nothing marked last
    write_width(16'd0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h55, 1'b1);
    write_width(16'hFFFF);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h81, 1'b1);
    write_width(16'd1);
    send_byte(8'h80, 1'b1);
    send_byte(8'h7F, 1'b0);
    send_byte(8'hFF, 1'b1);
    write_width(16'd12);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hF7, 1'b0);
    send_byte(8'h3C, 1'b0);
    send_byte(8'hA9, 1'b1);

    phase = 0;
    while (words_sent < ItemGoal) begin
      if (phase < corner_widths.size()) begin
        w = corner_widths[phase];
      end else begin
        case ($urandom_range(0, 9))
          7, 8:    w = 16'($urandom_range(41, 2400));
          9:       w = 16'($urandom_range(0, 65535));
          default: w = 16'($urandom_range(1, 40));
        endcase
      end
      write_width(w);
      calm = (phase % 5 == 4) || (phase == HoldPhase);
      if (phase == HoldPhase) begin
        hold_req = 1'b1;
      end
      phase_start = words_sent;
      phase_goal  = $urandom_range(40, 100);
      while (words_sent - phase_start < phase_goal) begin
        send_image(w);
        if (phase == PausePhase) begin
          wait_idle();
        end
      end
      phase++;
    end

    wait_idle();
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("bitmap_row_bit_packer_test: done, clean");
    end else begin
      $display("bitmap_row_bit_packer_test: done, errors");
    end
    $finish;
  end

  initial begin
    #(TimeoutNs);
    $display("bitmap_row_bit_packer_test: done, errors");
    $finish;
  end

endmodule
